// ===== hw/rtl/load_safety_cutoff_controller_unit_defines.svh =====
// Assertion macros shared by the load safety cutoff controller RTL.
// Included by the top level; the macros expand to nothing under synthesis.
`ifndef LOAD_SAFETY_CUTOFF_CONTROLLER_UNIT_DEFINES_SVH
`define LOAD_SAFETY_CUTOFF_CONTROLLER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LSCC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lscc assertion failed");
`define LSCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lscc assertion failed");
`else
`define LSCC_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/lscc_pkg.sv =====
// Types and constants of the load safety cutoff controller.
// Used by lscc_step and load_safety_cutoff_controller_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lscc_pkg;

   localparam int POWER_W   = 19;
   localparam int CURRENT_W = 17;
   localparam int MS_W      = 20;
   localparam int SECS_W    = 10;

   localparam logic [1:0] FUNC_READING = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_REMOTE  = 2'd2;

   localparam logic [1:0] CAUSE_BOOT      = 2'd0;
   localparam logic [1:0] CAUSE_REMOTE    = 2'd1;
   localparam logic [1:0] CAUSE_OVERPOWER = 2'd2;
   localparam logic [1:0] CAUSE_COUNTDOWN = 2'd3;

   localparam logic [1:0] REG_POWER_LIMIT    = 2'd0;
   localparam logic [1:0] REG_CURRENT_DETECT = 2'd1;
   localparam logic [1:0] REG_COUNTDOWN      = 2'd2;
   localparam logic [1:0] REG_ACTIVE_LOW     = 2'd3;

   localparam logic [POWER_W-1:0]   POWER_LIMIT_RESET    = 19'd10000;
   localparam logic [CURRENT_W-1:0] CURRENT_DETECT_RESET = 17'd50;
   localparam logic [MS_W-1:0]      COUNTDOWN_RESET      = 20'd30000;

   // Rounding up to seconds: floor((ms + 999) * RECIP >> 31) equals the
   // quotient by 1000 for every 21-bit sum.
   localparam logic [MS_W:0]        MS_ROUND   = 21'd999;
   localparam logic [21:0]          SECS_RECIP = 22'd2147484;
   localparam int                   SECS_SHIFT = 31;
   localparam logic [SECS_W-1:0]    SECS_MAX   = 10'd1023;

   typedef struct packed {
      logic [POWER_W-1:0]   power_limit_dw;
      logic [CURRENT_W-1:0] current_detect_ma;
      logic [MS_W-1:0]      countdown_ms;
      logic                 drive_active_low;
   } lscc_cfg_type;

   typedef struct packed {
      logic            relays_energized;
      logic [1:0]      last_cause;
      logic            shutdown_latch;
      logic            countdown_running;
      logic            remote_override;
      logic [MS_W-1:0] remaining_ms;
   } lscc_state_type;

   typedef struct packed {
      logic              relay_on;
      logic              drive_level;
      logic [1:0]        cause;
      logic              counting_down;
      logic [SECS_W-1:0] seconds_left;
      logic              latched_off;
      logic              override_held;
   } lscc_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lscc_step.sv =====
// Next-state and result logic for one event of the cutoff controller.
// Depends on lscc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lscc_step
   import lscc_pkg::*;
(
   input  wire lscc_cfg_type         cfg,
   input  wire lscc_state_type       state,
   input  wire [1:0]                 func,
   input  wire [POWER_W-1:0]         power_dw,
   input  wire [CURRENT_W-1:0]       current_ma,
   input  wire                       remote_on,
   output lscc_state_type            state_next,
   output lscc_result_type           result
);

   logic                  detected;
   logic [MS_W-1:0]       ms_dec;
   logic [MS_W:0]         ms_sum;
   logic [42:0]           secs_prod;
   logic [11:0]           secs_raw;
   logic [SECS_W-1:0]     secs_sat;

   always_comb begin
      state_next = state;
      detected   = current_ma >= cfg.current_detect_ma;
      ms_dec     = (state.remaining_ms != '0) ? state.remaining_ms - 1'b1 : '0;
      case (func)
         FUNC_READING: begin
            if (power_dw > cfg.power_limit_dw) begin
               state_next.shutdown_latch    = 1'b1;
               state_next.countdown_running = 1'b0;
               state_next.remaining_ms      = '0;
               state_next.relays_energized  = 1'b0;
               state_next.last_cause        = CAUSE_OVERPOWER;
            end else if (!state.shutdown_latch) begin
               if (state.remote_override) begin
                  if (!detected) begin
                     state_next.remote_override = 1'b0;
                  end
               end else if (detected && !state.countdown_running) begin
                  state_next.countdown_running = 1'b1;
                  state_next.remaining_ms      = cfg.countdown_ms;
               end else if (!detected && state.countdown_running) begin
                  state_next.countdown_running = 1'b0;
                  state_next.remaining_ms      = '0;
               end
            end
         end
         FUNC_TICK: begin
            if (state.countdown_running) begin
               state_next.remaining_ms = ms_dec;
               if (ms_dec == '0) begin
                  state_next.countdown_running = 1'b0;
                  state_next.shutdown_latch    = 1'b1;
                  state_next.relays_energized  = 1'b0;
                  state_next.last_cause        = CAUSE_COUNTDOWN;
               end
            end
         end
         FUNC_REMOTE: begin
            state_next.countdown_running = 1'b0;
            state_next.remaining_ms      = '0;
            state_next.relays_energized  = remote_on;
            state_next.last_cause        = CAUSE_REMOTE;
            state_next.shutdown_latch    = !remote_on;
            if (remote_on) begin
               state_next.remote_override = 1'b1;
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   always_comb begin
      ms_sum    = {1'b0, state_next.remaining_ms} + MS_ROUND;
      secs_prod = 43'(ms_sum) * 43'(SECS_RECIP);
      secs_raw  = secs_prod[42:SECS_SHIFT];
      secs_sat  = (secs_raw > {2'b00, SECS_MAX}) ? SECS_MAX : secs_raw[SECS_W-1:0];

      result.relay_on      = state_next.relays_energized;
      result.drive_level   = state_next.relays_energized ^ cfg.drive_active_low;
      result.cause         = state_next.last_cause;
      result.counting_down = state_next.countdown_running;
      result.seconds_left  = state_next.countdown_running ? secs_sat : '0;
      result.latched_off   = state_next.shutdown_latch;
      result.override_held = state_next.remote_override;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/load_safety_cutoff_controller_unit.sv =====
// Top level of the load safety cutoff controller: channels, registers, checks.
// Depends on lscc_pkg, lscc_step and load_safety_cutoff_controller_unit_defines.svh.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  tdata readings, tuser event kind
//   rsp      out        rsp_tvalid/rsp_tready  tdata relay and countdown status
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// An accepted beat enters the input register, then the output register that presents it.
// A new beat is taken in every cycle; the input and output registers form a two-stage
// pipeline, and req_tready drops only while both hold a beat and the result is not taken.
// The controller state is updated when a beat leaves the input register.
// Reset restores the boot state and default register values; csr_ready stays high.
`timescale 1ns / 1ps
`default_nettype none
`include "load_safety_cutoff_controller_unit_defines.svh"

module load_safety_cutoff_controller_unit
   import lscc_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [18:0] power_dw, [35:19] current_ma, [36] remote_on, [39:37] zero
   input  wire  [39:0] req_tdata,
   // [1:0] func
   input  wire  [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [0] relay_on, [1] drive_level, [3:2] cause, [4] counting_down,
   // [14:5] seconds_left, [15] latched_off, [16] override_held, [23:17] zero
   output logic [23:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [19:0] csr_data
);

   lscc_cfg_type            cfg_ff, cfg_in;
   lscc_state_type          state_ff, state_in;
   lscc_result_type         result;

   logic                    in_valid_ff, in_valid_in;
   logic [1:0]              in_func_ff;
   logic [POWER_W-1:0]      in_power_ff;
   logic [CURRENT_W-1:0]    in_current_ff;
   logic                    in_remote_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   lscc_result_type         rsp_data_ff;
   logic                    advance;
   logic                    take_req;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   lscc_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .func       (in_func_ff),
      .power_dw   (in_power_ff),
      .current_ma (in_current_ff),
      .remote_on  (in_remote_ff),
      .state_next (state_in),
      .result     (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POWER_LIMIT:    cfg_in.power_limit_dw    = csr_data[POWER_W-1:0];
            REG_CURRENT_DETECT: cfg_in.current_detect_ma = csr_data[CURRENT_W-1:0];
            REG_COUNTDOWN:      cfg_in.countdown_ms      = csr_data[MS_W-1:0];
            REG_ACTIVE_LOW:     cfg_in.drive_active_low  = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_limit_dw         <= POWER_LIMIT_RESET;
         cfg_ff.current_detect_ma      <= CURRENT_DETECT_RESET;
         cfg_ff.countdown_ms           <= COUNTDOWN_RESET;
         cfg_ff.drive_active_low       <= 1'b1;
         state_ff.relays_energized     <= 1'b1;
         state_ff.last_cause           <= CAUSE_BOOT;
         state_ff.shutdown_latch       <= 1'b0;
         state_ff.countdown_running    <= 1'b0;
         state_ff.remote_override      <= 1'b0;
         state_ff.remaining_ms         <= '0;
         in_valid_ff                   <= 1'b0;
         rsp_valid_ff                  <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_func_ff    <= req_tuser;
         in_power_ff   <= req_tdata[18:0];
         in_current_ff <= req_tdata[35:19];
         in_remote_ff  <= req_tdata[36];
      end
      if (in_valid_ff && advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000,
                        rsp_data_ff.override_held,
                        rsp_data_ff.latched_off,
                        rsp_data_ff.seconds_left,
                        rsp_data_ff.counting_down,
                        rsp_data_ff.cause,
                        rsp_data_ff.drive_level,
                        rsp_data_ff.relay_on};

   `LSCC_ASSERT_SAME(a_latch_opens_relays, clock, reset, state_ff.shutdown_latch, !state_ff.relays_energized)
   `LSCC_ASSERT_SAME(a_countdown_only_armed, clock, reset, state_ff.countdown_running, !state_ff.shutdown_latch && !state_ff.remote_override)
   `LSCC_ASSERT_SAME(a_idle_time_cleared, clock, reset, !state_ff.countdown_running, state_ff.remaining_ms == '0)
   `LSCC_ASSERT_NEXT(a_beat_reaches_output, clock, reset, in_valid_ff && advance, rsp_tvalid)

endmodule

`default_nettype wire

// ===== verif/tb_load_safety_cutoff_controller_unit.sv =====
// Self-checking testbench for load_safety_cutoff_controller_unit: a directed table, then
// random event streams under several register settings, checked against a local predictor.
// Depends on lscc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_load_safety_cutoff_controller_unit;
   import lscc_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;
   typedef enum logic [1:0] {TREADY_ALWAYS, TREADY_COIN, TREADY_SPARSE, TREADY_PERIODIC}
      tready_mode_e;

   typedef struct {
      row_kind_e            kind;
      logic [1:0]           reg_index;
      logic [19:0]          reg_value;
      logic [1:0]           func;
      logic [POWER_W-1:0]   power;
      logic [CURRENT_W-1:0] current;
      logic                 remote;
      logic                 typed;
      lscc_result_type      want;
   } step_row_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [19:0] csr_data;

   lscc_state_type  ctl_state;
   lscc_cfg_type    ctl_cfg;
   lscc_result_type pending_status[$];
   lscc_result_type predicted;
   lscc_result_type got;
   lscc_result_type want;
   lscc_result_type beat_exp;
   logic            beat_typed;
   step_row_t       directed_rows[$];

   int mismatches = 0;
   int beats_accepted = 0;
   int overpower_trips = 0;
   int countdown_trips = 0;
   int settings_used = 0;
   int burst_left = 0;

   tready_mode_e tready_mode = TREADY_ALWAYS;
   int           tready_left = 0;

   load_safety_cutoff_controller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic lscc_result_type result_of(input logic relay, input logic drive,
         input logic [1:0] cause, input logic counting, input logic [SECS_W-1:0] secs,
         input logic latched, input logic held);
      lscc_result_type r;
      r.relay_on      = relay;
      r.drive_level   = drive;
      r.cause         = cause;
      r.counting_down = counting;
      r.seconds_left  = secs;
      r.latched_off   = latched;
      r.override_held = held;
      return r;
   endfunction

   // Applies one event to the local controller state and returns the status it reports.
   function automatic lscc_result_type advance_controller(input logic [1:0] func,
         input logic [POWER_W-1:0] power, input logic [CURRENT_W-1:0] current,
         input logic remote);
      logic            detected;
      logic [MS_W:0]   rounded;
      lscc_result_type status;
      case (func)
         FUNC_READING: begin
            if (power > ctl_cfg.power_limit_dw) begin
               ctl_state.shutdown_latch    = 1'b1;
               ctl_state.countdown_running = 1'b0;
               ctl_state.remaining_ms      = '0;
               ctl_state.relays_energized  = 1'b0;
               ctl_state.last_cause        = CAUSE_OVERPOWER;
               overpower_trips = overpower_trips + 1;
            end
            if (!ctl_state.shutdown_latch) begin
               detected = current >= ctl_cfg.current_detect_ma;
               if (ctl_state.remote_override) begin
                  if (!detected) ctl_state.remote_override = 1'b0;
               end else if (detected && !ctl_state.countdown_running) begin
                  ctl_state.countdown_running = 1'b1;
                  ctl_state.remaining_ms      = ctl_cfg.countdown_ms;
               end else if (!detected && ctl_state.countdown_running) begin
                  ctl_state.countdown_running = 1'b0;
                  ctl_state.remaining_ms      = '0;
               end
            end
         end
         FUNC_TICK: begin
            if (ctl_state.countdown_running) begin
               if (ctl_state.remaining_ms != '0)
                  ctl_state.remaining_ms = ctl_state.remaining_ms - 1'b1;
               if (ctl_state.remaining_ms == '0) begin
                  ctl_state.countdown_running = 1'b0;
                  ctl_state.shutdown_latch    = 1'b1;
                  ctl_state.relays_energized  = 1'b0;
                  ctl_state.last_cause        = CAUSE_COUNTDOWN;
                  countdown_trips = countdown_trips + 1;
               end
            end
         end
         FUNC_REMOTE: begin
            ctl_state.countdown_running = 1'b0;
            ctl_state.remaining_ms      = '0;
            ctl_state.shutdown_latch    = !remote;
            ctl_state.relays_energized  = remote;
            ctl_state.last_cause        = CAUSE_REMOTE;
            if (remote) ctl_state.remote_override = 1'b1;
         end
         default: ;
      endcase
      rounded = '0;
      if (ctl_state.countdown_running)
         rounded = ({1'b0, ctl_state.remaining_ms} + 21'd999) / 21'd1000;
      status.relay_on      = ctl_state.relays_energized;
      status.drive_level   = ctl_state.relays_energized ^ ctl_cfg.drive_active_low;
      status.cause         = ctl_state.last_cause;
      status.counting_down = ctl_state.countdown_running;
      status.seconds_left  = (rounded > 21'd1023) ? SECS_MAX : rounded[SECS_W-1:0];
      status.latched_off   = ctl_state.shutdown_latch;
      status.override_held = ctl_state.remote_override;
      return status;
   endfunction

   task automatic check_field(input string name, input int unsigned exp_v,
         input int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatches = mismatches + 1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         ctl_state = '0;
         ctl_state.relays_energized = 1'b1;
         ctl_state.last_cause = CAUSE_BOOT;
         ctl_cfg.power_limit_dw    = POWER_LIMIT_RESET;
         ctl_cfg.current_detect_ma = CURRENT_DETECT_RESET;
         ctl_cfg.countdown_ms      = COUNTDOWN_RESET;
         ctl_cfg.drive_active_low  = 1'b1;
         pending_status.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_status.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               mismatches = mismatches + 1;
            end else begin
               want = pending_status.pop_front();
               got.relay_on      = rsp_tdata[0];
               got.drive_level   = rsp_tdata[1];
               got.cause         = rsp_tdata[3:2];
               got.counting_down = rsp_tdata[4];
               got.seconds_left  = rsp_tdata[14:5];
               got.latched_off   = rsp_tdata[15];
               got.override_held = rsp_tdata[16];
               check_field("relay_on", want.relay_on, got.relay_on);
               check_field("drive_level", want.drive_level, got.drive_level);
               check_field("cause", want.cause, got.cause);
               check_field("counting_down", want.counting_down, got.counting_down);
               check_field("seconds_left", want.seconds_left, got.seconds_left);
               check_field("latched_off", want.latched_off, got.latched_off);
               check_field("override_held", want.override_held, got.override_held);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_POWER_LIMIT:    ctl_cfg.power_limit_dw    = csr_data[POWER_W-1:0];
               REG_CURRENT_DETECT: ctl_cfg.current_detect_ma = csr_data[CURRENT_W-1:0];
               REG_COUNTDOWN:      ctl_cfg.countdown_ms      = csr_data[MS_W-1:0];
               REG_ACTIVE_LOW:     ctl_cfg.drive_active_low  = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predicted = advance_controller(req_tuser, req_tdata[18:0], req_tdata[35:19],
               req_tdata[36]);
            pending_status.push_back(beat_typed ? beat_exp : predicted);
            beats_accepted = beats_accepted + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (tready_left == 0) begin
         tready_mode <= tready_mode_e'($urandom_range(0, 3));
         tready_left <= $urandom_range(20, 200);
      end else begin
         tready_left <= tready_left - 1;
      end
      case (tready_mode)
         TREADY_ALWAYS:   rsp_tready <= 1'b1;
         TREADY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         TREADY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
         TREADY_PERIODIC: rsp_tready <= tready_left[2];
         default:         rsp_tready <= 1'b1;
      endcase
   end

   task automatic send_beat(input logic [1:0] func, input logic [POWER_W-1:0] power,
         input logic [CURRENT_W-1:0] current, input logic remote, input logic typed,
         input lscc_result_type exp_status);
      int          gap;
      logic [63:0] junk;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            junk = {$urandom, $urandom};
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= {3'b000, junk[36:0]};
            req_tuser  <= junk[38:37];
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {3'b000, remote, current, power};
      beat_typed <= typed;
      beat_exp   <= exp_status;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [19:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_beat(input logic [1:0] func, input logic [POWER_W-1:0] power,
         input logic [CURRENT_W-1:0] current, input logic remote, input logic typed,
         input lscc_result_type exp_status);
      step_row_t row;
      row.kind      = ROW_BEAT;
      row.reg_index = REG_POWER_LIMIT;
      row.reg_value = '0;
      row.func      = func;
      row.power     = power;
      row.current   = current;
      row.remote    = remote;
      row.typed     = typed;
      row.want      = exp_status;
      directed_rows.push_back(row);
   endtask

   task automatic add_write(input logic [1:0] index, input logic [19:0] value);
      step_row_t row;
      row.kind      = ROW_WRITE;
      row.reg_index = index;
      row.reg_value = value;
      row.func      = FUNC_READING;
      row.power     = '0;
      row.current   = '0;
      row.remote    = 1'b0;
      row.typed     = 1'b0;
      row.want      = '0;
      directed_rows.push_back(row);
   endtask

   task automatic send_random_beat;
      logic [1:0]           func;
      logic [POWER_W-1:0]   power;
      logic [CURRENT_W-1:0] current;
      logic [31:0]          pick;
      logic [31:0]          raw;
      pick = $urandom_range(0, 99);
      func = (pick < 45) ? FUNC_READING : (pick < 85) ? FUNC_TICK :
             (pick < 97) ? FUNC_REMOTE : FUNC_UNUSED;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: power = raw[POWER_W-1:0];
         1: power = (ctl_cfg.power_limit_dw == 19'h7FFFF) ? 19'h7FFFF :
                    ctl_cfg.power_limit_dw + 1'b1;
         default: power = 19'($urandom_range(0, ctl_cfg.power_limit_dw));
      endcase
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: current = raw[CURRENT_W-1:0];
         1: current = ctl_cfg.current_detect_ma;
         2: current = (ctl_cfg.current_detect_ma == '0) ? '0 :
                      ctl_cfg.current_detect_ma - 1'b1;
         3, 4, 5, 6: current = 17'($urandom_range(ctl_cfg.current_detect_ma, 17'h1FFFF));
         default: current = 17'($urandom_range(0, ctl_cfg.current_detect_ma));
      endcase
      send_beat(func, power, current, ($urandom_range(0, 9) < 7), 1'b0, '0);
   endtask

   initial begin : stimulus
      logic [POWER_W-1:0]   limit_v;
      logic [CURRENT_W-1:0] detect_v;
      logic [MS_W-1:0]      countdown_v;
      logic                 low_v;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = FUNC_READING;
      beat_typed = 1'b0;
      beat_exp   = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_POWER_LIMIT;
      csr_data   = '0;

      // Reset settings: limit 10000, detect 50, countdown 30000 ms, active-low drive.
      add_beat(FUNC_UNUSED, 19'h7FFFF, 17'h1FFFF, 1'b1, 1'b1,
         result_of(1, 0, CAUSE_BOOT, 0, 0, 0, 0));
      add_beat(FUNC_TICK, 0, 0, 1'b0, 1'b1, result_of(1, 0, CAUSE_BOOT, 0, 0, 0, 0));
      add_beat(FUNC_READING, 0, 0, 1'b0, 1'b1, result_of(1, 0, CAUSE_BOOT, 0, 0, 0, 0));
      add_beat(FUNC_READING, 10000, 50, 1'b0, 1'b1,
         result_of(1, 0, CAUSE_BOOT, 1, 30, 0, 0));
      add_beat(FUNC_TICK, 0, 0, 1'b0, 1'b0, '0);
      add_beat(FUNC_READING, 10000, 49, 1'b0, 1'b0, '0);
      add_beat(FUNC_READING, 19'h7FFFF, 17'h1FFFF, 1'b0, 1'b1,
         result_of(0, 1, CAUSE_OVERPOWER, 0, 0, 1, 0));
      add_beat(FUNC_READING, 0, 17'h1FFFF, 1'b0, 1'b0, '0);
      add_beat(FUNC_TICK, 0, 0, 1'b0, 1'b0, '0);
      add_beat(FUNC_REMOTE, 0, 0, 1'b1, 1'b1, result_of(1, 0, CAUSE_REMOTE, 0, 0, 0, 1));
      add_beat(FUNC_READING, 0, 100000, 1'b0, 1'b0, '0);
      add_beat(FUNC_READING, 10001, 100000, 1'b0, 1'b1,
         result_of(0, 1, CAUSE_OVERPOWER, 0, 0, 1, 1));
      add_beat(FUNC_REMOTE, 19'h7FFFF, 17'h1FFFF, 1'b1, 1'b0, '0);
      add_beat(FUNC_READING, 0, 0, 1'b0, 1'b0, '0);
      add_beat(FUNC_READING, 0, 100000, 1'b0, 1'b0, '0);
      add_beat(FUNC_REMOTE, 0, 0, 1'b0, 1'b1, result_of(0, 1, CAUSE_REMOTE, 0, 0, 1, 0));
      add_beat(FUNC_REMOTE, 0, 0, 1'b1, 1'b0, '0);
      add_beat(FUNC_READING, 0, 0, 1'b0, 1'b0, '0);
      // A zero countdown arms with nothing left and trips on the next tick.
      add_write(REG_COUNTDOWN, 20'd0);
      add_write(REG_ACTIVE_LOW, 20'd0);
      add_beat(FUNC_READING, 0, 50, 1'b0, 1'b0, '0);
      add_beat(FUNC_TICK, 0, 0, 1'b0, 1'b1, result_of(0, 0, CAUSE_COUNTDOWN, 0, 0, 1, 0));
      add_beat(FUNC_REMOTE, 0, 0, 1'b1, 1'b0, '0);
      add_beat(FUNC_READING, 0, 0, 1'b0, 1'b0, '0);
      // The longest countdown saturates the seconds field.
      add_write(REG_COUNTDOWN, 20'hFFFFF);
      add_write(REG_POWER_LIMIT, 20'd0);
      add_write(REG_CURRENT_DETECT, 20'd0);
      add_beat(FUNC_READING, 0, 0, 1'b0, 1'b1,
         result_of(1, 1, CAUSE_REMOTE, 1, 1023, 0, 0));
      add_beat(FUNC_TICK, 0, 0, 1'b0, 1'b0, '0);
      add_beat(FUNC_READING, 1, 0, 1'b0, 1'b0, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settings_used = 3;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            drain_results();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_beat(directed_rows[i].func, directed_rows[i].power,
               directed_rows[i].current, directed_rows[i].remote,
               directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               limit_v = 5000; detect_v = 500; countdown_v = 5; low_v = 1'b0;
            end
            1: begin
               limit_v = 0; detect_v = 0; countdown_v = 0; low_v = 1'b1;
            end
            2: begin
               limit_v = 19'h7FFFF; detect_v = 17'h1FFFF; countdown_v = 20'hFFFFF;
               low_v = 1'b0;
            end
            3: begin
               limit_v = 300000; detect_v = 100000; countdown_v = 600000; low_v = 1'b1;
            end
            4: begin
               limit_v = 20000; detect_v = 1000; countdown_v = 1; low_v = 1'b0;
            end
            5, 6: begin
               limit_v     = 19'($urandom_range(0, 300000));
               detect_v    = 17'($urandom_range(0, 2000));
               countdown_v = 20'($urandom_range(0, 30));
               low_v       = 1'($urandom_range(0, 1));
            end
            default: begin
               limit_v = 10000; detect_v = 50; countdown_v = 12; low_v = 1'b1;
            end
         endcase
         drain_results();
         write_reg(REG_POWER_LIMIT, {1'b0, limit_v});
         write_reg(REG_CURRENT_DETECT, {3'b000, detect_v});
         write_reg(REG_COUNTDOWN, countdown_v);
         write_reg(REG_ACTIVE_LOW, {19'd0, low_v});
         settings_used = settings_used + 1;
         repeat (175) send_random_beat();
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Run covered %0d request beats under %0d register settings.",
         beats_accepted, settings_used);
      $display("Predicted trips: %0d over-power, %0d countdown; %0d mismatches.",
         overpower_trips, countdown_trips, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $error("timeout with %0d results outstanding", pending_status.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lscc_pkg.sv
hw/rtl/lscc_step.sv
hw/rtl/load_safety_cutoff_controller_unit.sv
verif/tb_load_safety_cutoff_controller_unit.sv
